/* hdl/dam_pkg.sv */
// Shared types and constants for the decimal accumulator machine.
`default_nettype none

package dam_pkg;

    // Request kinds carried in the slave-side tuser field.
    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_EXEC    = 2'd1,
        REQ_RESTART = 2'd2
    } req_t;

    // Hundreds digit of an instruction word.
    typedef enum logic [3:0] {
        OP_HLT = 4'd0,
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_STA = 4'd3,
        OP_LDA = 4'd5,
        OP_BRA = 4'd6,
        OP_BRZ = 4'd7,
        OP_BRP = 4'd8,
        OP_IO  = 4'd9
    } opcode_t;

    // Address digits that select input or output under the I/O opcode.
    localparam logic [6:0] IO_INP = 7'd1;
    localparam logic [6:0] IO_OUT = 7'd2;

    // Smallest word that no longer decodes to a defined three-digit instruction.
    localparam int unsigned WORD_LIMIT = 1000;

    // floor(x / 100) for x below 1000 equals (x * 41) >> 12.
    localparam logic [15:0] DIV100_MUL   = 16'd41;
    localparam logic [9:0]  DIGIT_WEIGHT = 10'd100;

    localparam int unsigned S_TDATA_BITS = 24;
    localparam int unsigned M_TDATA_BITS = 48;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FETCH = 2'd1,
        ST_OPER  = 2'd2
    } state_t;

    // Fields of a fetched instruction word.
    typedef struct packed {
        logic       is_zero;
        logic       is_bad;
        logic [3:0] op;
        logic [6:0] ad;
    } decode_t;

endpackage

`default_nettype wire

/* hdl/dam_ram.sv */
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module dam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                ram_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= ram_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/dam_decode.sv */
// Splits an instruction word into its opcode digit and address digits.
`default_nettype none

module dam_decode #(
    parameter int WORD_BITS = 16
) (
    input  wire logic [WORD_BITS-1:0] word,
    output dam_pkg::decode_t          dec
);

    import dam_pkg::*;

    logic [9:0]  low_digits;
    logic [15:0] scaled;
    logic [3:0]  quot;
    logic [9:0]  rem;

    // Only words from 1 to 999 are decoded, so ten bits carry the value.
    assign low_digits = word[9:0];
    assign scaled     = {6'd0, low_digits} * DIV100_MUL;
    assign quot       = scaled[15:12];
    assign rem        = low_digits - ({6'd0, quot} * DIGIT_WEIGHT);

    assign dec.is_zero = (word == '0);
    assign dec.is_bad  = word[WORD_BITS-1] || (word >= WORD_BITS'(WORD_LIMIT));
    assign dec.op      = quot;
    assign dec.ad      = rem[6:0];

endmodule

`default_nettype wire

/* hdl/decimal_accumulator_machine.sv */
// Top level of the decimal accumulator machine, a Little Man Computer core.
`default_nettype none

// This core runs decimal three-digit instructions out of a program store of
// STORE_WORDS words of WORD_BITS bits, all zero after reset. Every input
// transfer is a request (load a store word, execute one instruction, or
// restart at address zero) and yields exactly one output transfer holding the
// machine state after that request. The store is a single-port synchronous
// RAM with a registered read; per-word valid flags make unwritten words read
// as zero, so no clearing pass follows reset. The next request is taken as a
// load, a restart or an instruction without a data operand commits from the
// fetch stage, once the output register is free; ADD, SUB, LDA and STA also
// pass through the operand stage, because the operand access follows the
// instruction fetch on the same RAM port, and commit from that stage. The
// result is registered on the master side at commit, and the output register
// lets the next request enter while a result still waits for m_tready.
module decimal_accumulator_machine #(
    parameter int STORE_WORDS = 100,
    parameter int WORD_BITS   = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Bits from low: load_address [6:0], data_value [22:7], zero [23].
    input  wire logic [dam_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // Bits from low: req_type [1:0].
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Bits from low: out_value [15:0], halted [16], bad_opcode [17],
    // pc_value [24:18], acc_value [40:25], zero [47:41].
    output logic      [dam_pkg::M_TDATA_BITS-1:0]  m_tdata,
    // Bits from low: out_valid [0].
    output logic                                   m_tuser
);

    import dam_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);
    localparam logic [6:0]    STORE_LIMIT = 7'(STORE_WORDS);
    localparam logic [AW-1:0] PC_LAST     = AW'(STORE_WORDS - 1);

    // Control state.
    state_t                 state_reg, state_next;
    logic [AW-1:0]          pc_reg, pc_next;
    logic [WORD_BITS-1:0]   acc_reg, acc_next;
    logic                   halt_reg, halt_next;
    logic [STORE_WORDS-1:0] valid_reg;
    logic                   rd_ok_reg, rd_ok_next;
    logic                   m_tvalid_reg;

    // Request payload held while the request is at work.
    logic [1:0]             req_reg;
    logic signed [15:0]     data_reg;
    logic [3:0]             op_reg;

    // Output payload.
    logic [15:0]            oval_out_reg;
    logic                   halt_out_reg;
    logic                   bad_out_reg;
    logic [6:0]             pc_out_reg;
    logic [15:0]            acc_out_reg;
    logic                   ov_out_reg;

    // Stage results.
    logic [AW-1:0]          pc_calc;
    logic [WORD_BITS-1:0]   acc_calc;
    logic                   halt_calc;
    logic                   ov_calc;
    logic                   bad_calc;
    logic                   needs_mem;
    logic                   finish;
    logic                   commit;
    logic                   mem_step;
    logic                   out_free;
    logic                   accept;

    // Decoded fields of the fetched word.
    logic [WORD_BITS-1:0]   fetched_word;
    logic [WORD_BITS-1:0]   operand;
    decode_t                dec;
    logic [AW-1:0]          pc_inc;
    logic [AW-1:0]          branch_pc;
    logic                   ad_in_range;

    // Slave-side fields.
    logic [6:0]             s_load_address;
    logic signed [15:0]     s_data_value;
    logic [WORD_BITS-1:0]   load_word;
    logic [WORD_BITS-1:0]   inp_word;
    logic                   load_in_range;

    // Store port.
    logic                   ram_en;
    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [WORD_BITS-1:0]   ram_rdata;

    assign s_load_address = s_tdata[6:0];
    assign s_data_value   = s_tdata[22:7];
    assign load_word      = WORD_BITS'(s_data_value);
    assign inp_word       = WORD_BITS'(data_reg);
    assign load_in_range  = (s_load_address < STORE_LIMIT);

    // A word never written reads as zero; so does an address past the store.
    assign fetched_word = rd_ok_reg ? ram_rdata : '0;
    assign operand      = fetched_word;

    dam_decode #(
        .WORD_BITS (WORD_BITS)
    ) u_decode (
        .word (fetched_word),
        .dec  (dec)
    );

    assign ad_in_range = (dec.ad < STORE_LIMIT);
    assign pc_inc      = (pc_reg == PC_LAST) ? '0 : pc_reg + AW'(1);
    assign branch_pc   = ad_in_range ? dec.ad[AW-1:0] : '0;

    // Work of the current stage: the fetch stage decides every request, the
    // operand stage completes the accumulator for ADD, SUB and LDA.
    always_comb
    begin
        pc_calc   = pc_reg;
        acc_calc  = acc_reg;
        halt_calc = halt_reg;
        ov_calc   = 1'b0;
        bad_calc  = 1'b0;
        needs_mem = 1'b0;
        finish    = 1'b0;
        case (state_reg)
            ST_FETCH:
            begin
                finish = 1'b1;
                case (req_reg)
                    REQ_RESTART:
                    begin
                        pc_calc   = '0;
                        halt_calc = 1'b0;
                    end
                    REQ_EXEC:
                    begin
                        if (!halt_reg)
                        begin
                            if (dec.is_zero)
                            begin
                                halt_calc = 1'b1;
                            end
                            else if (dec.is_bad)
                            begin
                                bad_calc = 1'b1;
                                pc_calc  = pc_inc;
                            end
                            else
                            begin
                                pc_calc = pc_inc;
                                case (dec.op)
                                    OP_ADD, OP_SUB, OP_LDA, OP_STA:
                                    begin
                                        needs_mem = 1'b1;
                                        finish    = 1'b0;
                                    end
                                    OP_BRA:
                                    begin
                                        pc_calc = branch_pc;
                                    end
                                    OP_BRZ:
                                    begin
                                        if (acc_reg == '0)
                                        begin
                                            pc_calc = branch_pc;
                                        end
                                    end
                                    OP_BRP:
                                    begin
                                        if (!acc_reg[WORD_BITS-1])
                                        begin
                                            pc_calc = branch_pc;
                                        end
                                    end
                                    OP_IO:
                                    begin
                                        if (dec.ad == IO_INP)
                                        begin
                                            acc_calc = inp_word;
                                        end
                                        else if (dec.ad == IO_OUT)
                                        begin
                                            ov_calc = 1'b1;
                                        end
                                    end
                                    OP_HLT:
                                    begin
                                        // A zero hundreds digit with a nonzero address is a no-op.
                                    end
                                    default:
                                    begin
                                        bad_calc = 1'b1;
                                    end
                                endcase
                            end
                        end
                    end
                    default:
                    begin
                        // Loads were written when taken; unknown kinds change nothing.
                    end
                endcase
            end
            ST_OPER:
            begin
                finish = 1'b1;
                case (op_reg)
                    OP_ADD:
                    begin
                        acc_calc = acc_reg + operand;
                    end
                    OP_SUB:
                    begin
                        acc_calc = acc_reg - operand;
                    end
                    OP_LDA:
                    begin
                        acc_calc = operand;
                    end
                    default:
                    begin
                        // STA wrote the store in the fetch stage.
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // An idle machine takes a request even while a result waits; the request then
    // holds in the fetch stage, or in the operand stage for ADD, SUB, LDA and STA, until the output register frees up.
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = finish && out_free;
    assign mem_step = needs_mem;
    assign s_tready = (state_reg == ST_IDLE) || commit;
    assign accept   = s_tvalid && s_tready;

    assign pc_next   = (commit || mem_step) ? pc_calc : pc_reg;
    assign acc_next  = commit ? acc_calc : acc_reg;
    assign halt_next = commit ? halt_calc : halt_reg;

    // The store port serves the request being taken, or the operand access
    // of an instruction in the fetch stage; these never fall in one cycle.
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = pc_next;
        ram_wdata = acc_reg;
        if (accept)
        begin
            case (s_tuser)
                REQ_LOAD:
                begin
                    ram_en    = load_in_range;
                    ram_we    = 1'b1;
                    ram_addr  = s_load_address[AW-1:0];
                    ram_wdata = load_word;
                end
                REQ_EXEC:
                begin
                    ram_en   = 1'b1;
                    ram_addr = pc_next;
                end
                default:
                begin
                end
            endcase
        end
        else if (mem_step)
        begin
            ram_en   = ad_in_range;
            ram_we   = (dec.op == OP_STA);
            ram_addr = dec.ad[AW-1:0];
        end
    end

    assign rd_ok_next = ram_en && !ram_we && valid_reg[ram_addr];

    dam_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (needs_mem)
                begin
                    state_next = ST_OPER;
                end
                else if (commit)
                begin
                    state_next = accept ? ST_FETCH : ST_IDLE;
                end
            end
            ST_OPER:
            begin
                if (commit)
                begin
                    state_next = accept ? ST_FETCH : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pc_reg       <= '0;
            acc_reg      <= '0;
            halt_reg     <= 1'b0;
            valid_reg    <= '0;
            rd_ok_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            acc_reg   <= acc_next;
            halt_reg  <= halt_next;
            if (ram_en && ram_we)
            begin
                valid_reg[ram_addr] <= 1'b1;
            end
            if ((ram_en && !ram_we) || mem_step)
            begin
                rd_ok_reg <= rd_ok_next;
            end
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= s_tuser;
            data_reg <= s_data_value;
        end
        if (mem_step)
        begin
            op_reg <= dec.op;
        end
        if (commit)
        begin
            ov_out_reg   <= ov_calc;
            oval_out_reg <= ov_calc ? 16'(acc_reg) : 16'd0;
            halt_out_reg <= halt_calc;
            bad_out_reg  <= bad_calc;
            pc_out_reg   <= 7'(pc_calc);
            acc_out_reg  <= 16'(acc_calc);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = ov_out_reg;
    assign m_tdata  = {7'd0, acc_out_reg, pc_out_reg, bad_out_reg, halt_out_reg,
                       oval_out_reg};

endmodule

`default_nettype wire
